/* sv/i2p_pkg.sv */
// Package for the infix-to-postfix converter: stack sizing, character codes,
// operator precedence and display functions.
// No dependencies.
package i2p_pkg;

    // Operator stack sizing
    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

    typedef logic [7:0]          sym_t;
    typedef logic [2:0]          rank_t;
    typedef logic [STACK_CW-1:0] count_t;

    // Character codes
    localparam sym_t SYM_UPLUS  = 8'h40;  // '@' stacked unary plus
    localparam sym_t SYM_UMINUS = 8'h23;  // '#' stacked unary minus
    localparam sym_t SYM_OPEN   = 8'h28;  // '('
    localparam sym_t SYM_CLOSE  = 8'h29;  // ')'
    localparam sym_t SYM_OR     = 8'h7C;  // '|'
    localparam sym_t SYM_AND    = 8'h26;  // '&'
    localparam sym_t SYM_LT     = 8'h3C;  // '<'
    localparam sym_t SYM_GT     = 8'h3E;  // '>'
    localparam sym_t SYM_PLUS   = 8'h2B;  // '+'
    localparam sym_t SYM_MINUS  = 8'h2D;  // '-'
    localparam sym_t SYM_MUL    = 8'h2A;  // '*'
    localparam sym_t SYM_DIV    = 8'h2F;  // '/'
    localparam sym_t SYM_NOT    = 8'h21;  // '!'
    localparam sym_t SYM_NULL   = 8'h00;

    // Rank code for a plain operand
    localparam rank_t RANK_NONE = 3'd7;

    // Character class of the previous item
    localparam logic [1:0] CLASS_NONE    = 2'd0;
    localparam logic [1:0] CLASS_OPERAND = 2'd1;
    localparam logic [1:0] CLASS_OPER    = 2'd2;
    localparam logic [1:0] CLASS_OPEN    = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_UNMATCH  = 2'd2;

    // Precedence of a character, RANK_NONE for operands
    function automatic rank_t rank_f(input sym_t c);
        rank_t r;
        case (c)
            SYM_OPEN, SYM_CLOSE:            r = 3'd0;
            SYM_OR:                         r = 3'd1;
            SYM_AND:                        r = 3'd2;
            SYM_LT, SYM_GT:                 r = 3'd3;
            SYM_PLUS, SYM_MINUS:            r = 3'd4;
            SYM_MUL, SYM_DIV:               r = 3'd5;
            SYM_NOT, SYM_UPLUS, SYM_UMINUS: r = 3'd6;
            default:                        r = RANK_NONE;
        endcase
        return r;
    endfunction

    // Stacked unary signs leave the stack as plain signs
    function automatic sym_t shown_f(input sym_t c);
        sym_t s;
        if (c == SYM_UPLUS) begin
            s = SYM_PLUS;
        end else if (c == SYM_UMINUS) begin
            s = SYM_MINUS;
        end else begin
            s = c;
        end
        return s;
    endfunction

endpackage

/* sv/i2p_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/infix_to_postfix_converter_top.sv */
// Infix-to-postfix converter top level: control sequencer around the operator stack.
// Depends on i2p_pkg and i2p_ram.
//
// Takes one infix character per input transfer (tuser = 1 marks end of expression)
// and returns the postfix characters it releases, tlast on the final result of each
// item; an item that releases nothing returns no transfer. The operator stack lives
// in a RAM with registered read data, the top entry cached in a register. An item
// passes through S_IDLE, S_EVAL and S_FIN, plus S_LOAD and S_EVAL again for each
// operator popped off the stack, S_LOAD being the RAM read that refills the cached
// top; a ')' that drops its matching '(' adds a further S_LOAD for that refill. A
// result transfer that has to wait on m_axis_tready stretches the item by the stall.
// The next item is accepted while the last result still waits in the output register.
module infix_to_postfix_converter_top
    import i2p_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic [0:0] s_axis_tuser,   // [0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
    output logic [2:0] m_axis_tuser,   // [0] end_marker, [2:1] error_code
    output logic       m_axis_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    count_t     count_reg, count_next;
    sym_t       top_reg, top_next;
    sym_t       cur_reg, cur_next;
    logic       kind_reg, kind_next;
    logic       second_reg, second_next;
    logic       done_reg, done_next;
    logic       at_start_reg, at_start_next;
    logic [1:0] prev_class_reg, prev_class_next;
    logic       prev_prev_reg, prev_prev_next;
    logic       pending_reg, pending_next;

    // One-result hold so the final result of an item can carry tlast
    logic       hold_valid_reg, hold_valid_next;
    sym_t       hold_sym_reg, hold_sym_next;
    logic       hold_end_reg, hold_end_next;
    logic [1:0] hold_err_reg, hold_err_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    sym_t       m_sym_reg, m_sym_next;
    logic       m_end_reg, m_end_next;
    logic [1:0] m_err_reg, m_err_next;
    logic       m_last_reg, m_last_next;

    // Stack RAM ports
    logic                ram_we;
    logic [STACK_AW-1:0] ram_waddr;
    sym_t                ram_wdata;
    logic [STACK_AW-1:0] ram_raddr;
    sym_t                ram_rdata;
    count_t              count_m2;

    logic  s_fire, can_send, emit_ok;
    logic  emit_req, send_last;
    sym_t  emit_sym;
    logic  emit_end;
    logic  [1:0] emit_err;
    sym_t  in_sym, in_conv;
    rank_t in_rank, cur_rank, top_rank;
    logic  [1:0] in_class;
    logic  is_sign, is_unary;
    logic  cnt_nz, full;
    logic  do_pop, do_push;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign can_send      = !m_valid_reg || m_axis_tready;
    assign emit_ok       = !hold_valid_reg || can_send;

    // Input classification and unary sign detection
    assign in_sym   = s_axis_tdata;
    assign in_rank  = rank_f(in_sym);
    assign is_sign  = (in_sym == SYM_PLUS) || (in_sym == SYM_MINUS);
    assign is_unary = is_sign && (at_start_reg || (prev_class_reg == CLASS_OPEN) ||
                      ((prev_class_reg == CLASS_OPER) && prev_prev_reg));
    assign in_conv  = !is_unary ? in_sym : ((in_sym == SYM_PLUS) ? SYM_UPLUS : SYM_UMINUS);

    always_comb begin
        if (in_rank == RANK_NONE) begin
            in_class = CLASS_OPERAND;
        end else if (in_sym == SYM_OPEN) begin
            in_class = CLASS_OPEN;
        end else if (in_rank != 3'd0) begin
            in_class = CLASS_OPER;
        end else begin
            in_class = CLASS_NONE;
        end
    end

    assign cur_rank  = rank_f(cur_reg);
    assign top_rank  = rank_f(top_reg);
    assign cnt_nz    = (count_reg != '0);
    assign full      = (count_reg == STACK_CW'(STACK_DEPTH));
    assign count_m2  = count_reg - STACK_CW'(2);
    assign ram_raddr = count_m2[STACK_AW-1:0];

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        cur_next        = cur_reg;
        kind_next       = kind_reg;
        second_next     = second_reg;
        done_next       = done_reg;
        at_start_next   = at_start_reg;
        prev_class_next = prev_class_reg;
        prev_prev_next  = prev_prev_reg;
        pending_next    = pending_reg;
        emit_req        = 1'b0;
        emit_sym        = SYM_NULL;
        emit_end        = 1'b0;
        emit_err        = ERR_NONE;
        send_last       = 1'b0;
        do_pop          = 1'b0;
        do_push         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[STACK_AW-1:0];
        ram_wdata       = cur_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    kind_next   = s_axis_tuser[0];
                    cur_next    = in_conv;
                    second_next = pending_reg;
                    state_next  = S_EVAL;
                    if (s_axis_tuser[0]) begin
                        at_start_next   = 1'b1;
                        prev_class_next = CLASS_NONE;
                        prev_prev_next  = 1'b0;
                        pending_next    = 1'b0;
                    end else begin
                        prev_prev_next  = (prev_class_reg == CLASS_OPERAND);
                        prev_class_next = in_class;
                        at_start_next   = 1'b0;
                        pending_next    = 1'b0;
                    end
                end
            end
            S_EVAL: begin
                if (emit_ok) begin
                    if (kind_reg) begin
                        if (cnt_nz) begin
                            do_pop = 1'b1;
                        end else begin
                            emit_req   = 1'b1;
                            emit_end   = 1'b1;
                            state_next = S_FIN;
                        end
                    end else if (second_reg || (cur_reg == SYM_OPEN)) begin
                        do_push = 1'b1;
                    end else if (cur_rank == RANK_NONE) begin
                        emit_req   = 1'b1;
                        emit_sym   = cur_reg;
                        state_next = S_FIN;
                    end else if (cur_reg == SYM_CLOSE) begin
                        if (cnt_nz && (top_reg != SYM_OPEN)) begin
                            do_pop = 1'b1;
                        end else if (cnt_nz) begin
                            // Drop the matching open bracket, then refill the top
                            count_next = count_reg - count_t'(1);
                            done_next  = 1'b1;
                            state_next = S_LOAD;
                        end else begin
                            emit_req   = 1'b1;
                            emit_err   = ERR_UNMATCH;
                            state_next = S_FIN;
                        end
                    end else begin
                        if (cnt_nz && (top_rank != RANK_NONE) && (cur_rank <= top_rank)) begin
                            do_pop = 1'b1;
                        end else begin
                            do_push = 1'b1;
                            if ((cur_reg == SYM_OR) || (cur_reg == SYM_AND)) begin
                                pending_next = 1'b1;
                            end
                        end
                    end

                    // Pop: release the top, refill it from the RAM
                    if (do_pop) begin
                        emit_req   = 1'b1;
                        emit_sym   = shown_f(top_reg);
                        count_next = count_reg - count_t'(1);
                        done_next  = 1'b0;
                        state_next = S_LOAD;
                    end

                    // Push, or flag the drop on a full stack
                    if (do_push) begin
                        if (full) begin
                            emit_req = 1'b1;
                            emit_err = ERR_OVERFLOW;
                        end else begin
                            ram_we     = 1'b1;
                            top_next   = cur_reg;
                            count_next = count_reg + count_t'(1);
                        end
                        state_next = S_FIN;
                    end
                end
            end
            S_LOAD: begin
                top_next   = ram_rdata;
                state_next = done_reg ? S_FIN : S_EVAL;
            end
            S_FIN: begin
                if (!hold_valid_reg) begin
                    state_next = S_IDLE;
                end else if (can_send) begin
                    send_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold stage and output register
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_end_next   = hold_end_reg;
        hold_err_next   = hold_err_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_sym_next      = m_sym_reg;
        m_end_next      = m_end_reg;
        m_err_next      = m_err_reg;
        m_last_next     = m_last_reg;

        if ((emit_req && hold_valid_reg) || send_last) begin
            m_valid_next = 1'b1;
            m_sym_next   = hold_sym_reg;
            m_end_next   = hold_end_reg;
            m_err_next   = hold_err_reg;
            m_last_next  = send_last;
        end
        if (send_last) begin
            hold_valid_next = 1'b0;
        end
        if (emit_req) begin
            hold_valid_next = 1'b1;
            hold_sym_next   = emit_sym;
            hold_end_next   = emit_end;
            hold_err_next   = emit_err;
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            at_start_reg   <= 1'b1;
            prev_class_reg <= CLASS_NONE;
            prev_prev_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            at_start_reg   <= at_start_next;
            prev_class_reg <= prev_class_next;
            prev_prev_reg  <= prev_prev_next;
            pending_reg    <= pending_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        cur_reg      <= cur_next;
        kind_reg     <= kind_next;
        second_reg   <= second_next;
        done_reg     <= done_next;
        hold_sym_reg <= hold_sym_next;
        hold_end_reg <= hold_end_next;
        hold_err_reg <= hold_err_next;
        m_sym_reg    <= m_sym_next;
        m_end_reg    <= m_end_next;
        m_err_reg    <= m_err_next;
        m_last_reg   <= m_last_next;
    end

    // Operator stack storage
    i2p_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_sym_reg;
    assign m_axis_tuser  = {m_err_reg, m_end_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for infix_to_postfix_converter_top: directed and random infix expressions,
// each result transfer checked against a shunting-yard scoreboard kept in this file.
// Depends on i2p_pkg and the converter RTL.
module tb_top;
    import i2p_pkg::*;

    // One expected postfix result
    typedef struct {
        sym_t       sym;
        logic       end_mark;
        logic [1:0] err;
        logic       last;
    } emit_t;

    // Binary operators picked by the random expressions
    localparam sym_t BINARY_OPS [8] = '{SYM_OR, SYM_AND, SYM_LT, SYM_GT,
                                        SYM_PLUS, SYM_MINUS, SYM_MUL, SYM_DIV};

    // Shunting-yard predictor plus the queue of results still owed by the block
    class postfix_scoreboard;
        sym_t       opstack [STACK_DEPTH];
        int         depth;
        bit         expr_start;
        logic [1:0] last_class;
        bit         last_last_operand;
        bit         second_char_due;
        emit_t      batch [$];
        emit_t      pending [$];
        int         failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            depth             = 0;
            expr_start        = 1'b1;
            last_class        = CLASS_NONE;
            last_last_operand = 1'b0;
            second_char_due   = 1'b0;
        endfunction

        // Precedence, -1 for operands
        function int prec(sym_t c);
            case (c)
                SYM_OPEN, SYM_CLOSE:            return 0;
                SYM_OR:                         return 1;
                SYM_AND:                        return 2;
                SYM_LT, SYM_GT:                 return 3;
                SYM_PLUS, SYM_MINUS:            return 4;
                SYM_MUL, SYM_DIV:               return 5;
                SYM_NOT, SYM_UPLUS, SYM_UMINUS: return 6;
                default:                        return -1;
            endcase
        endfunction

        function void add(sym_t s, logic e, logic [1:0] err);
            emit_t r;
            r.sym      = s;
            r.end_mark = e;
            r.err      = err;
            r.last     = 1'b0;
            batch.push_back(r);
        endfunction

        // Pop the top operator; stacked unary signs come out as plain signs
        function void pop_op();
            sym_t s;
            depth--;
            s = opstack[depth];
            if (s == SYM_UPLUS) begin
                s = SYM_PLUS;
            end else if (s == SYM_UMINUS) begin
                s = SYM_MINUS;
            end
            add(s, 1'b0, ERR_NONE);
        endfunction

        // Full stack drops the push and reports it
        function void push_op(sym_t c);
            if (depth >= STACK_DEPTH) begin
                add(SYM_NULL, 1'b0, ERR_OVERFLOW);
            end else begin
                opstack[depth] = c;
                depth++;
            end
        endfunction

        // Called on every accepted input transfer
        function void take_char(bit kind, sym_t ch);
            sym_t       c;
            logic [1:0] cls;
            int         p;
            batch.delete();
            if (kind) begin
                while (depth > 0) pop_op();
                add(SYM_NULL, 1'b1, ERR_NONE);
                restart();
            end else begin
                c = ch;
                p = prec(c);
                cls = (p == -1) ? CLASS_OPERAND : (c == SYM_OPEN) ? CLASS_OPEN :
                      (p >= 1) ? CLASS_OPER : CLASS_NONE;
                // sign is unary at start, after '(' or after an operator that follows an operand
                if ((c == SYM_PLUS || c == SYM_MINUS) &&
                    (expr_start || last_class == CLASS_OPEN ||
                     (last_class == CLASS_OPER && last_last_operand))) begin
                    c = (c == SYM_PLUS) ? SYM_UPLUS : SYM_UMINUS;
                end
                p = prec(c);
                last_last_operand = (last_class == CLASS_OPERAND);
                last_class        = cls;
                expr_start        = 1'b0;

                if (second_char_due) begin
                    second_char_due = 1'b0;
                    push_op(c);
                end else if (p == -1) begin
                    add(c, 1'b0, ERR_NONE);
                end else if (c == SYM_OPEN) begin
                    push_op(c);
                end else if (c == SYM_CLOSE) begin
                    while (depth > 0 && opstack[depth-1] != SYM_OPEN) pop_op();
                    if (depth > 0) begin
                        depth--;
                    end else begin
                        add(SYM_NULL, 1'b0, ERR_UNMATCH);
                    end
                end else begin
                    while (depth > 0 && p <= prec(opstack[depth-1])) pop_op();
                    push_op(c);
                    if (c == SYM_OR || c == SYM_AND) begin
                        second_char_due = 1'b1;
                    end
                end
            end
            if (batch.size() > 0) begin
                batch[batch.size()-1].last = 1'b1;
            end
            foreach (batch[i]) pending.push_back(batch[i]);
        endfunction

        // Called on every accepted result transfer
        function void check_emit(sym_t s, logic e, logic [1:0] err, logic l);
            emit_t want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("[%0t] unexpected result: sym=%02h end=%0d err=%0d last=%0d",
                             $realtime, s, e, err, l);
                end
            end else begin
                want = pending.pop_front();
                if (want.sym !== s || want.end_mark !== e || want.err !== err ||
                    want.last !== l) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("[%0t] mismatch: exp sym=%02h end=%0d err=%0d last=%0d",
                                 $realtime, want.sym, want.end_mark, want.err, want.last);
                        $display("[%0t]           got sym=%02h end=%0d err=%0d last=%0d",
                                 $realtime, s, e, err, l);
                    end
                end
            end
        endfunction
    endclass

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic [0:0] s_axis_tuser  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    postfix_scoreboard sb = new();

    int   burst_left  = 0;
    int   items_sent  = 0;
    int   stall_mode  = 0;
    int   stall_span  = 0;
    sym_t expr_chars [$];

    always #6 aclk = ~aclk;

    infix_to_postfix_converter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // One input transfer; bursts of random length separated by random gaps
    task automatic send_item(input bit kind, input sym_t ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= kind;
        do @(posedge aclk); while (!s_axis_tready);
        sb.take_char(kind, ch);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_item(1'b0, txt[i]);
    endtask

    task automatic send_end();
        send_item(1'b1, sym_t'($urandom_range(0, 255)));
    endtask

    // Receiver: check accepted results, then stall on a changing pattern
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_emit(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1], m_axis_tlast);
        end
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (stall_span % 4 == 0);
            default: m_axis_tready <= (stall_span % 16 < 8);
        endcase
    end

    // Stimulus and end of run
    initial begin
        int   terms;
        int   open_cnt;
        int   drain;
        sym_t op;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Unary after '(' and after an operator that follows an operand; '(' left on flush
        send_text("(-a*-b");
        send_end();
        // Unary at start, field extremes, ')' taken as second character of '|'
        send_item(1'b0, SYM_PLUS);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, SYM_LT);
        send_item(1'b0, 8'h00);
        send_text("|)");
        send_end();
        // Raw stacked signs, binary minus, '!' and an unmatched close
        send_text("@a-b>!#c/d)");
        send_end();
        // Overflow: deep nesting, then '&' and its second character both dropped
        repeat (STACK_DEPTH + 2) send_item(1'b0, SYM_OPEN);
        send_item(1'b0, SYM_AND);
        send_item(1'b0, "z");
        send_end();

        // Random part: mostly well-formed expressions, some noise and broken input
        while (items_sent < 170) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 4))
                        send_item($urandom_range(0, 5) == 0, sym_t'($urandom_range(0, 255)));
                end
                1: begin
                    repeat ($urandom_range(1, 8)) begin
                        case ($urandom_range(0, 2))
                            0: send_item(1'b0, BINARY_OPS[$urandom_range(0, 7)]);
                            1: send_item(1'b0, $urandom_range(0, 1) ? SYM_OPEN : SYM_CLOSE);
                            default: send_item(1'b0, sym_t'("a" + $urandom_range(0, 25)));
                        endcase
                    end
                end
                default: begin
                    expr_chars.delete();
                    terms    = $urandom_range(1, 6);
                    open_cnt = 0;
                    for (int i = 0; i < terms; i++) begin
                        while ($urandom_range(0, 3) == 0 && open_cnt < 6) begin
                            expr_chars.push_back(SYM_OPEN);
                            open_cnt++;
                        end
                        if ($urandom_range(0, 3) == 0) begin
                            case ($urandom_range(0, 2))
                                0: expr_chars.push_back(SYM_PLUS);
                                1: expr_chars.push_back(SYM_MINUS);
                                default: expr_chars.push_back(SYM_NOT);
                            endcase
                        end
                        if ($urandom_range(0, 1)) begin
                            expr_chars.push_back(sym_t'("a" + $urandom_range(0, 25)));
                        end else begin
                            expr_chars.push_back(sym_t'("0" + $urandom_range(0, 9)));
                        end
                        while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
                            expr_chars.push_back(SYM_CLOSE);
                            open_cnt--;
                        end
                        if (i < terms - 1) begin
                            op = BINARY_OPS[$urandom_range(0, 7)];
                            expr_chars.push_back(op);
                            // logical operators take a second character, usually a repeat
                            if (op == SYM_OR || op == SYM_AND) begin
                                expr_chars.push_back(($urandom_range(0, 3) != 0) ? op :
                                                     sym_t'($urandom_range(0, 255)));
                            end
                        end
                    end
                    while (open_cnt > 0 && $urandom_range(0, 4) != 0) begin
                        expr_chars.push_back(SYM_CLOSE);
                        open_cnt--;
                    end
                    foreach (expr_chars[i]) send_item(1'b0, expr_chars[i]);
                    send_end();
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // Drain what is still owed, then watch for stray results
        drain = 0;
        while (sb.pending.size() > 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (100) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $display("%0d expected results never arrived", sb.pending.size());
        end
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
